[rtl/core/ack_pkg.sv]
`timescale 1ns / 1ps

package ack_pkg;

    localparam int MAX_STATES  = 5;
    localparam int MAX_ENTRIES = 2 * MAX_STATES;
    localparam int DIGIT_W     = 3;
    localparam int KEY_W       = DIGIT_W * MAX_ENTRIES;
    localparam int CODE_W      = 26;
    localparam int FIELD_W     = 4;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 32;

    typedef logic [MAX_STATES-1:0][DIGIT_W-1:0]  t_perm;
    typedef logic [MAX_ENTRIES-1:0][DIGIT_W-1:0] t_table;
    typedef logic [KEY_W-1:0]                    t_key;
    typedef logic [CODE_W-1:0]                   t_code;

    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

    function automatic int factorial(input int n);
        int acc;
        acc = 1;
        for (int i = 2; i <= MAX_STATES; i++) begin
            if (i <= n) begin
                acc = acc * i;
            end
        end
        return acc;
    endfunction

    function automatic int code_limit(input int n);
        int acc;
        acc = 1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i < 2 * n) begin
                acc = acc * 6;
            end
        end
        return acc - 1;
    endfunction

    // idx-th permutation in lexicographic order, by repeated next-permutation
    function automatic t_perm nth_perm(input int idx, input int n);
        t_perm p;
        t_perm q;
        int    pivot;
        int    swp;
        logic [DIGIT_W-1:0] tmp;
        for (int s = 0; s < MAX_STATES; s++) begin
            p[s] = DIGIT_W'(s);
        end
        for (int k = 0; k < idx; k++) begin
            pivot = -1;
            for (int i = 0; i < MAX_STATES - 1; i++) begin
                if (i < n - 1 && p[i] < p[i+1]) begin
                    pivot = i;
                end
            end
            if (pivot >= 0) begin
                swp = pivot;
                for (int j = 0; j < MAX_STATES; j++) begin
                    if (j < n && j > pivot && p[j] > p[pivot]) begin
                        swp = j;
                    end
                end
                tmp      = p[pivot];
                p[pivot] = p[swp];
                p[swp]   = tmp;
                q = p;
                for (int i = 0; i < MAX_STATES; i++) begin
                    if (i > pivot && i < n) begin
                        p[i] = q[n + pivot - i];
                    end
                end
            end
        end
        return p;
    endfunction

endpackage

[rtl/core/ack_perm_cell.sv]
`timescale 1ns / 1ps

module ack_perm_cell #(
    parameter int           NUM_STATES = 5,
    parameter ack_pkg::t_perm PERM     = '0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ack_pkg::t_stage_ctl i_ctl,
    input  ack_pkg::t_table    i_table,
    input  ack_pkg::t_key      i_best,
    output logic               o_valid,
    output ack_pkg::t_table    o_table,
    output ack_pkg::t_key      o_best
);

    ack_pkg::t_table w_moved;
    ack_pkg::t_key   w_key;
    logic                        r_valid;
    ack_pkg::t_table             r_table;
    ack_pkg::t_key               r_best;
    ack_pkg::t_key               n_best;
    logic [ack_pkg::DIGIT_W-1:0] w_t;

    // relabel rows and targets
    always_comb begin
        w_moved = '0;
        w_t     = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            for (int b = 0; b < 2; b++) begin
                w_t = i_table[2*s+b];
                for (int u = 0; u < NUM_STATES; u++) begin
                    if (w_t == ack_pkg::DIGIT_W'(u + 1)) begin
                        w_moved[2*PERM[s]+b] = PERM[u] + ack_pkg::DIGIT_W'(1);
                    end
                end
            end
        end
    end

    // first entry in the most significant digit
    always_comb begin
        w_key = '0;
        for (int k = 0; k < 2 * NUM_STATES; k++) begin
            w_key[(2*NUM_STATES-1-k)*ack_pkg::DIGIT_W +: ack_pkg::DIGIT_W] = w_moved[k];
        end
    end

    assign n_best = (w_key < i_best) ? w_key : i_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_table <= i_table;
            r_best  <= n_best;
        end
    end

    assign o_valid = r_valid;
    assign o_table = r_table;
    assign o_best  = r_best;

endmodule

[rtl/core/ack_digit_cell.sv]
`timescale 1ns / 1ps

module ack_digit_cell #(
    parameter int NUM_STATES = 5,
    parameter int DIGIT_IDX  = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ack_pkg::t_stage_ctl i_ctl,
    input  ack_pkg::t_key       i_best,
    input  ack_pkg::t_code      i_code,
    output logic                o_valid,
    output ack_pkg::t_key       o_best,
    output ack_pkg::t_code      o_code
);

    localparam int LSB = (2 * NUM_STATES - 1 - DIGIT_IDX) * ack_pkg::DIGIT_W;

    logic                        r_valid;
    ack_pkg::t_key               r_best;
    ack_pkg::t_code              r_code;
    ack_pkg::t_code              n_code;
    logic [ack_pkg::DIGIT_W-1:0] w_digit;

    assign w_digit = i_best[LSB +: ack_pkg::DIGIT_W];
    // code * 6 + digit
    assign n_code  = (i_code << 2) + (i_code << 1) + ack_pkg::CODE_W'(w_digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_best <= i_best;
            r_code <= n_code;
        end
    end

    assign o_valid = r_valid;
    assign o_best  = r_best;
    assign o_code  = r_code;

endmodule

[rtl/core/automaton_canonical_key.sv]
`timescale 1ns / 1ps

// channel  | dir | width | contents
// s_axis   | in  | 40    | ten 4-bit signed targets, next_s0_on0 lowest
// m_axis   | out | 32    | canonical_code in bits 25:0
//
// one table accepted per cycle while the skid register is empty, one key per table
// the chain has one cell per relabeling,
// then one cell per base-6 digit, then the output register
// the cell chain moves on whenever the skid register is empty
// a stalled output fills the skid register, then the chain holds
// synchronous active-low reset clears all valid flags

module automaton_canonical_key #(
    parameter int NUM_STATES = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // next_s0_on0, next_s0_on1, ... next_s4_on1, 4 bits each
    input  logic [ack_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // canonical_code (26 bits), zero fill
    output logic [ack_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    localparam int NUM_CELLS  = ack_pkg::factorial(NUM_STATES);
    localparam int NUM_DIGITS = 2 * NUM_STATES;
    localparam int MAX_CODE   = ack_pkg::code_limit(NUM_STATES);

    logic                          w_adv;
    ack_pkg::t_table               w_in_table;
    logic            [NUM_CELLS:0] w_valid;
    ack_pkg::t_table [NUM_CELLS:0] w_table;
    ack_pkg::t_key   [NUM_CELLS:0] w_best;
    logic            [NUM_DIGITS:0] d_valid;
    ack_pkg::t_key   [NUM_DIGITS:0] d_best;
    ack_pkg::t_code  [NUM_DIGITS:0] d_code;

    logic           r_out_valid;
    ack_pkg::t_code r_out_code;
    logic           r_skid_valid;
    ack_pkg::t_code r_skid_code;
    logic           w_out_take;

    assign w_adv = !r_skid_valid;

    // out-of-range targets count as undefined
    always_comb begin
        w_in_table = '0;
        for (int k = 0; k < ack_pkg::MAX_ENTRIES; k++) begin
            if (!i_s_axis_tdata[k*ack_pkg::FIELD_W+3] &&
                i_s_axis_tdata[k*ack_pkg::FIELD_W +: 3] < ack_pkg::DIGIT_W'(NUM_STATES)) begin
                w_in_table[k] = i_s_axis_tdata[k*ack_pkg::FIELD_W +: 3] + ack_pkg::DIGIT_W'(1);
            end
        end
    end

    assign w_valid[0] = i_s_axis_tvalid;
    assign w_table[0] = w_in_table;
    assign w_best[0]  = '1;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_perm
        localparam ack_pkg::t_perm P = ack_pkg::nth_perm(i, NUM_STATES);
        ack_pkg::t_stage_ctl w_ctl;
        assign w_ctl.en    = w_adv;
        assign w_ctl.valid = w_valid[i];
        ack_perm_cell #(
            .NUM_STATES (NUM_STATES),
            .PERM       (P)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_table (w_table[i]),
            .i_best  (w_best[i]),
            .o_valid (w_valid[i+1]),
            .o_table (w_table[i+1]),
            .o_best  (w_best[i+1])
        );
    end

    assign d_valid[0] = w_valid[NUM_CELLS];
    assign d_best[0]  = w_best[NUM_CELLS];
    assign d_code[0]  = '0;

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
        ack_pkg::t_stage_ctl w_ctl;
        assign w_ctl.en    = w_adv;
        assign w_ctl.valid = d_valid[k];
        ack_digit_cell #(
            .NUM_STATES (NUM_STATES),
            .DIGIT_IDX  (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_best  (d_best[k]),
            .i_code  (d_code[k]),
            .o_valid (d_valid[k+1]),
            .o_best  (d_best[k+1]),
            .o_code  (d_code[k+1])
        );
    end

    assign w_out_take = r_out_valid && i_m_axis_tready;

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (d_valid[NUM_DIGITS]) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_code <= r_skid_code;
            end
        end else if (d_valid[NUM_DIGITS]) begin
            if (!r_out_valid || w_out_take) begin
                r_out_code <= d_code[NUM_DIGITS];
            end else begin
                r_skid_code <= d_code[NUM_DIGITS];
            end
        end
    end

    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(ack_pkg::OUT_DATA_W - ack_pkg::CODE_W)'(0), r_out_code};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a key while the output is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> w_valid[1])
        else $error("accepted table did not enter the first cell");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code <= ack_pkg::CODE_W'(MAX_CODE)))
        else $error("key exceeds the code range");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(w_best[NUM_CELLS]))
        else $error("cell chain moved while the skid register was full");

endmodule

[dv/tb_automaton_canonical_key.sv]
`timescale 1ns / 1ps

module tb_automaton_canonical_key;

    localparam int N_ST         = 5;
    localparam int N_PERM       = 120;
    localparam int LATENCY      = N_PERM + 2 * N_ST + 1;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 1300;
    localparam int HOLD_LEN     = 500;
    localparam int QUIET_LO     = 400;
    localparam int QUIET_HI     = 800;
    localparam int FIELD_UNDEF  = -1;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [ack_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           o_m_axis_tvalid;
    logic                           m_tready = 1'b0;
    logic [ack_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;

    logic [ack_pkg::IN_DATA_W-1:0]  table_q [$];
    ack_pkg::t_code                 key_q [$];
    int                             relabel [N_PERM][N_ST];
    int                             tables_sent = 0;
    int                             keys_seen = 0;
    int                             bad_keys = 0;
    int                             hold_left = 0;
    int                             stall_cycles = 0;

    automaton_canonical_key #(
        .NUM_STATES(N_ST)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic queue_table(input logic [ack_pkg::IN_DATA_W-1:0] tbl);
        table_q.insert(table_q.size(), tbl);
    endtask

    task automatic expect_key(input ack_pkg::t_code key);
        key_q.insert(key_q.size(), key);
    endtask

    // least base-6 code of the table over every relabelling of the states
    function automatic ack_pkg::t_code least_key(input logic [ack_pkg::IN_DATA_W-1:0] tbl);
        int    target [ack_pkg::MAX_ENTRIES];
        int    moved [ack_pkg::MAX_ENTRIES];
        int    t;
        longint code;
        longint best;
        best = 64'h7fff_ffff_ffff_ffff;
        for (int k = 0; k < 2 * N_ST; k++) begin
            target[k] = $signed(tbl[ack_pkg::FIELD_W*k +: ack_pkg::FIELD_W]);
            if (target[k] < 0 || target[k] >= N_ST) begin
                target[k] = FIELD_UNDEF;
            end
        end
        for (int p = 0; p < N_PERM; p++) begin
            for (int s = 0; s < N_ST; s++) begin
                for (int b = 0; b < 2; b++) begin
                    t = target[2*s+b];
                    moved[2*relabel[p][s]+b] = (t == FIELD_UNDEF) ? FIELD_UNDEF : relabel[p][t];
                end
            end
            code = 0;
            for (int k = 0; k < 2 * N_ST; k++) begin
                code = code * 6 + moved[k] + 1;
            end
            if (code < best) begin
                best = code;
            end
        end
        return ack_pkg::t_code'(best);
    endfunction

    // per-table density of undefined entries, with some wild out-of-range fields
    function automatic logic [ack_pkg::IN_DATA_W-1:0] random_table();
        logic [ack_pkg::IN_DATA_W-1:0] tbl;
        int                            undef_pct;
        bit                            wild;
        undef_pct = $urandom_range(0, 60);
        wild      = ($urandom_range(0, 99) < 15);
        tbl       = '0;
        for (int k = 0; k < ack_pkg::MAX_ENTRIES; k++) begin
            if (wild && $urandom_range(0, 3) == 0) begin
                tbl[ack_pkg::FIELD_W*k +: ack_pkg::FIELD_W] =
                    ack_pkg::FIELD_W'($urandom_range(0, 15));
            end else if ($urandom_range(0, 99) < undef_pct) begin
                tbl[ack_pkg::FIELD_W*k +: ack_pkg::FIELD_W] = ack_pkg::FIELD_W'(FIELD_UNDEF);
            end else begin
                tbl[ack_pkg::FIELD_W*k +: ack_pkg::FIELD_W] =
                    ack_pkg::FIELD_W'($urandom_range(0, N_ST - 1));
            end
        end
        return tbl;
    endfunction

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (table_q.size() != 0 || s_tvalid || key_q.size() != 0);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                expect_key(least_key(s_tdata));
                tables_sent++;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (table_q.size() != 0 && ((tables_sent >= QUIET_LO && tables_sent < QUIET_HI)
                        || $urandom_range(0, 99) >= 9)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= table_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        ack_pkg::t_code want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                keys_seen++;
                if (key_q.size() == 0) begin
                    bad_keys++;
                    if (bad_keys <= 10) begin
                        $display("unexpected key %h", o_m_axis_tdata);
                    end
                end else begin
                    want = key_q.pop_front();
                    if (o_m_axis_tdata !==
                            {{(ack_pkg::OUT_DATA_W-ack_pkg::CODE_W){1'b0}}, want}) begin
                        bad_keys++;
                        if (bad_keys <= 10) begin
                            $display("key mismatch: expected %0d got %0d (raw %h)",
                                     want, o_m_axis_tdata[ack_pkg::CODE_W-1:0],
                                     o_m_axis_tdata);
                        end
                    end
                end
                if (keys_seen == HOLD_AT) begin
                    hold_left = HOLD_LEN;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (keys_seen >= QUIET_LO && keys_seen < QUIET_HI)
                            || $urandom_range(0, 99) >= 9;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("automaton_canonical_key verification failed");
                $finish;
            end
        end
    end

    initial begin
        int  n;
        int  d;
        int  pick [N_ST];
        bit  clash;
        n = 0;
        for (int idx = 0; idx < N_ST ** N_ST; idx++) begin
            d     = idx;
            clash = 1'b0;
            for (int s = 0; s < N_ST; s++) begin
                pick[s] = d % N_ST;
                d       = d / N_ST;
                for (int r = 0; r < s; r++) begin
                    if (pick[r] == pick[s]) begin
                        clash = 1'b1;
                    end
                end
            end
            if (!clash) begin
                for (int s = 0; s < N_ST; s++) begin
                    relabel[n][s] = pick[s];
                end
                n++;
            end
        end

        // extremes, out-of-range targets, chains, self loops, lone entries
        queue_table(40'hFFFF_FFFF_FF);
        queue_table(40'h0000_0000_00);
        queue_table(40'h4444_4444_44);
        queue_table(40'h7777_7777_77);
        queue_table(40'h8888_8888_88);
        queue_table(40'h5555_5555_55);
        queue_table(40'hEEEE_EEEE_EE);
        queue_table(40'h6666_6666_66);
        queue_table(40'hAAAA_AAAA_AA);
        queue_table(40'h7878_7878_78);
        queue_table(40'hF0F4_F3F2_F1);
        queue_table(40'h4433_2211_00);
        queue_table(40'h0FFF_FFFF_FF);
        queue_table(40'hFFFF_FFFF_F4);
        queue_table(40'h0123_4012_34);
        queue_table(40'h4321_0432_10);
        queue_table(40'h9669_A55A_3C);
        queue_table(40'h1F0F_3F2F_4F);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drain();
        for (int i = 0; i < 900; i++) begin
            queue_table(random_table());
        end
        wait_drain();
        for (int i = 0; i < 1050; i++) begin
            queue_table(random_table());
        end
        wait_drain();
        repeat (LATENCY + 20) @(posedge i_clk);

        if (bad_keys == 0 && key_q.size() == 0) begin
            $display("automaton_canonical_key verification clean");
        end else begin
            $display("automaton_canonical_key verification failed");
        end
        $finish;
    end

endmodule
